// ===== src/distinct_element_deque_defines.svh =====
// Assertion macros shared by the distinct element deque RTL.
`ifndef DISTINCT_ELEMENT_DEQUE_DEFINES_SVH
`define DISTINCT_ELEMENT_DEQUE_DEFINES_SVH

`ifndef SYNTH
// Clocked check that is ignored while reset is asserted.
`define DED_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset.
`define DED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DED_ASSERT(lbl, clk, rst_n, prop, msg)
`define DED_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/ded_pkg.sv =====
// Types and constants of the distinct element deque.
`default_nettype none

package ded_pkg;

    // Domain and store sizing.
    localparam int MAX_DOMAIN = 64;
    localparam int IDX_W      = $clog2(MAX_DOMAIN);
    localparam int CNT_W      = $clog2(MAX_DOMAIN + 1);
    localparam int VAL_W      = 6;
    localparam int FUNC_W     = 3;
    localparam int CFG_W      = 7;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

    // One command transfer.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    // One result transfer.
    typedef struct packed {
        logic              status;
        logic [VAL_W-1:0]  popped_value;
        logic              was_member;
        logic [6:0]        count;
        logic              is_empty;
        logic              is_full;
    } t_result;

endpackage

`default_nettype wire

// ===== src/ded_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ded_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/distinct_element_deque.sv =====
// A command accepted at a clock edge shows its result in the next cycle, for one cycle.
// Throughput: one command every cycle; busy stays low, as every operation touches only
// the head, the tail, one slot store location and one membership bit.
// A popped value leaves the slot store read register in the next cycle; its membership
// bit is cleared then and forwarded to the next command. Reset sets the domain size to
// 64 and empties the queue at once: the membership bitmap is flops, so no clearing pass.
`default_nettype none
`include "distinct_element_deque_defines.svh"

module distinct_element_deque
    import ded_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             start,
    input  wire t_cmd             i_cmd,
    output logic                  busy,
    output logic                  o_valid,
    output t_result               o_result
);

    logic [CNT_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      r_tail;
    logic [MAX_DOMAIN-1:0] r_present;
    logic                  r_valid;
    logic                  r_pop_ok;
    t_result               r_res;

    logic [CNT_W-1:0]      n_count;
    logic [IDX_W-1:0]      n_head;
    logic [IDX_W-1:0]      n_tail;
    logic [MAX_DOMAIN-1:0] n_present;
    t_result               n_res;

    logic                  accept;
    logic                  in_dom;
    logic                  member;
    logic                  push_ok;
    logic                  pop_ok;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W-1:0]      head_prev;
    logic [IDX_W-1:0]      head_next;
    logic [IDX_W-1:0]      tail_prev;
    logic [IDX_W-1:0]      tail_next;
    logic [IDX_W-1:0]      rd_addr;
    logic [VAL_W-1:0]      w_rdata;
    logic [CNT_W-1:0]      cfg_n;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Slot store.
    ded_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_DOMAIN)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (accept && push_ok && !i_cfg_we),
        .i_waddr(slot),
        .i_wdata(i_cmd.value),
        .i_raddr(rd_addr),
        .o_rdata(w_rdata)
    );

    // Saturate the written domain size to 1..MAX_DOMAIN.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_n = CNT_W'(1);
        end else if (i_cfg_wdata > CFG_W'(MAX_DOMAIN)) begin
            cfg_n = CNT_W'(MAX_DOMAIN);
        end else begin
            cfg_n = CNT_W'(i_cfg_wdata);
        end
    end

    // Circular neighbors of the head and tail within the active domain.
    always_comb begin
        head_prev = (r_head == '0) ? IDX_W'(r_n - CNT_W'(1)) : r_head - IDX_W'(1);
        tail_prev = (r_tail == '0) ? IDX_W'(r_n - CNT_W'(1)) : r_tail - IDX_W'(1);
        head_next = (CNT_W'(r_head) + CNT_W'(1) >= r_n) ? '0 : r_head + IDX_W'(1);
        tail_next = (CNT_W'(r_tail) + CNT_W'(1) >= r_n) ? '0 : r_tail + IDX_W'(1);
    end

    // Command decode and next state.
    always_comb begin
        in_dom  = CNT_W'(i_cmd.value) < r_n;
        // A pop from the previous cycle clears its bit only now, so forward it.
        member  = r_present[i_cmd.value] && !(r_pop_ok && (w_rdata == i_cmd.value));
        push_ok = 1'b0;
        pop_ok  = 1'b0;
        slot    = '0;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        rd_addr = (i_cmd.func == FUNC_POP_FRONT) ? r_head : r_tail;
        n_res   = '0;
        n_res.status = 1'b1;

        case (i_cmd.func) inside
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                if (in_dom) begin
                    n_res.was_member = member;
                    if (!member) begin
                        n_res.status = 1'b0;
                        push_ok      = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        if (r_count == '0) begin
                            n_head = '0;
                            n_tail = '0;
                            slot   = '0;
                        end else if (i_cmd.func == FUNC_PUSH_FRONT) begin
                            n_head = head_prev;
                            slot   = head_prev;
                        end else begin
                            n_tail = tail_next;
                            slot   = tail_next;
                        end
                    end
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
                if (r_count != '0) begin
                    n_res.status = 1'b0;
                    pop_ok       = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                    // Popping the last element keeps the indices where they are.
                    if (r_count != CNT_W'(1)) begin
                        if (i_cmd.func == FUNC_POP_FRONT) begin
                            n_head = head_next;
                        end else begin
                            n_tail = tail_prev;
                        end
                    end
                end
            end
            FUNC_QUERY: begin
                if (in_dom) begin
                    n_res.status     = 1'b0;
                    n_res.was_member = member;
                end
            end
            default: begin
            end
        endcase

        n_res.count    = 7'(n_count);
        n_res.is_empty = (n_count == '0);
        n_res.is_full  = (n_count == r_n);
    end

    // Membership bitmap: late clear of the last popped value, then a new push.
    always_comb begin
        n_present = r_present;
        if (r_pop_ok) begin
            n_present[w_rdata] = 1'b0;
        end
        if (accept && push_ok) begin
            n_present[i_cmd.value] = 1'b1;
        end
    end

    // Queue state; a configuration write empties the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= CNT_W'(MAX_DOMAIN);
            r_count   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_present <= '0;
            r_valid   <= 1'b0;
            r_pop_ok  <= 1'b0;
        end else begin
            r_valid  <= accept;
            r_pop_ok <= accept && pop_ok && !i_cfg_we;
            if (i_cfg_we) begin
                r_n       <= cfg_n;
                r_count   <= '0;
                r_head    <= '0;
                r_tail    <= '0;
                r_present <= '0;
            end else begin
                r_present <= n_present;
                if (accept) begin
                    r_count <= n_count;
                    r_head  <= n_head;
                    r_tail  <= n_tail;
                end
            end
        end
    end

    // Result register; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    // Result transfer, with the popped value taken from the slot store read register.
    always_comb begin
        o_valid               = r_valid;
        o_result              = r_res;
        o_result.popped_value = r_pop_ok ? w_rdata : '0;
    end

    `DED_ASSERT(a_count_in_domain, i_clk, i_rst_n, r_count <= r_n, "count exceeds domain size")
    `DED_ASSERT(a_result_follows, i_clk, i_rst_n, accept |=> o_valid, "accepted command gave no result")
    `DED_ASSERT(a_no_spurious, i_clk, i_rst_n, !accept |=> !o_valid, "result without a command")
    `DED_ASSERT(a_reject_keeps, i_clk, i_rst_n, (o_valid && o_result.status) |-> ((o_result.popped_value == '0) && (o_result.count == 7'($past(r_count)))), "rejected command changed the queue")

endmodule

`default_nettype wire

// ===== tb/sv/distinct_element_deque_tb.sv =====
// Self-checking testbench for the distinct element deque, with a shadow deque predictor.
`default_nettype none

module distinct_element_deque_tb
    import ded_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam real CLK_PERIOD    = 4.0;
    localparam int  RESET_CYCLES  = 5;
    localparam int  SETTLE_CYCLES = 3;
    localparam int  STALL_LIMIT   = 1000;
    localparam int  PHASE_ITEMS   = 160;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_RESERVED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_LAST  = 3'd7;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             start       = 1'b0;
    t_cmd             i_cmd       = '0;
    logic             busy;
    logic             o_valid;
    t_result          o_result;

    // Shadow copy of the deque state and of the domain size register.
    logic [VAL_W-1:0] shadow_slot [MAX_DOMAIN];
    logic             shadow_present [MAX_DOMAIN];
    int               shadow_head;
    int               shadow_tail;
    logic             shadow_empty;
    logic [CFG_W-1:0] shadow_domain;

    t_result pending_results[$];
    int      mismatches   = 0;
    int      stall_cycles = 0;
    bit      idling_on    = 1'b1;

    distinct_element_deque dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // The domain size saturates to the range 1..MAX_DOMAIN.
    function automatic int effective_domain();
        if (shadow_domain < 1) return 1;
        if (shadow_domain > MAX_DOMAIN) return MAX_DOMAIN;
        return int'(shadow_domain);
    endfunction

    function automatic int queue_occupancy(int n);
        if (shadow_empty) return 0;
        if (shadow_tail >= shadow_head) return shadow_tail - shadow_head + 1;
        return n + shadow_tail - shadow_head + 1;
    endfunction

    // Emptying keeps the slot contents.
    function automatic void clear_shadow_queue();
        foreach (shadow_present[i]) shadow_present[i] = 1'b0;
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_empty = 1'b1;
    endfunction

    // Applies one command to the shadow deque and returns the result it should produce.
    function automatic t_result apply_deque_op(t_cmd c);
        t_result r;
        int      n;
        int      occ;
        int      slot;
        logic    in_domain;
        n         = effective_domain();
        in_domain = int'(c.value) < n;
        r         = '0;
        r.status  = STATUS_REJECTED;
        case (c.func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                if (in_domain) begin
                    r.was_member = shadow_present[c.value];
                    if (!r.was_member) begin
                        r.status = STATUS_DONE;
                        if (shadow_empty) begin
                            // A push into an empty deque restarts both ends at slot 0.
                            shadow_head  = 0;
                            shadow_tail  = 0;
                            shadow_empty = 1'b0;
                            slot         = 0;
                        end else if (c.func == FUNC_PUSH_FRONT) begin
                            shadow_head = (shadow_head == 0) ? n - 1 : shadow_head - 1;
                            slot        = shadow_head;
                        end else begin
                            shadow_tail = (shadow_tail + 1 >= n) ? 0 : shadow_tail + 1;
                            slot        = shadow_tail;
                        end
                        shadow_slot[slot]       = c.value;
                        shadow_present[c.value] = 1'b1;
                    end
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
                if (!shadow_empty) begin
                    r.status       = STATUS_DONE;
                    slot           = (c.func == FUNC_POP_FRONT) ? shadow_head : shadow_tail;
                    r.popped_value = shadow_slot[slot];
                    shadow_present[r.popped_value] = 1'b0;
                    // Popping the last element leaves both indices where they are.
                    if (queue_occupancy(n) == 1) begin
                        shadow_empty = 1'b1;
                    end else if (c.func == FUNC_POP_FRONT) begin
                        shadow_head = (shadow_head + 1 >= n) ? 0 : shadow_head + 1;
                    end else begin
                        shadow_tail = (shadow_tail == 0) ? n - 1 : shadow_tail - 1;
                    end
                end
            end
            FUNC_QUERY: begin
                if (in_domain) begin
                    r.status     = STATUS_DONE;
                    r.was_member = shadow_present[c.value];
                end
            end
            default: ;
        endcase
        occ        = queue_occupancy(n);
        r.count    = 7'(occ);
        r.is_empty = (occ == 0);
        r.is_full  = (occ == n);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [6:0] got,
                               input logic [6:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Compare every result transfer with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with no prediction waiting");
            end else begin
                want = pending_results.pop_front();
                check_field("status", 7'(o_result.status), 7'(want.status));
                check_field("popped_value", 7'(o_result.popped_value), 7'(want.popped_value));
                check_field("was_member", 7'(o_result.was_member), 7'(want.was_member));
                check_field("count", o_result.count, want.count);
                check_field("is_empty", 7'(o_result.is_empty), 7'(want.is_empty));
                check_field("is_full", 7'(o_result.is_full), 7'(want.is_full));
            end
        end
    end

    // Ends the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1 || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one command, records its prediction, then sometimes idles while idling is on.
    task automatic send_command(input logic [FUNC_W-1:0] func, input logic [VAL_W-1:0] value);
        t_cmd cmd;
        cmd.func  = func;
        cmd.value = value;
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_deque_op(cmd));
        if (idling_on && $urandom_range(0, 99) < 15) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_domain_size(input logic [CFG_W-1:0] size);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        shadow_domain = size;
        clear_shadow_queue();
        i_cfg_we <= 1'b0;
    endtask

    // Pops and queries on an empty deque, and reserved operation codes.
    task automatic test_empty_deque_rejects();
        send_command(FUNC_QUERY, 6'd0);
        send_command(FUNC_POP_FRONT, 6'd0);
        send_command(FUNC_POP_BACK, 6'd63);
        send_command(FUNC_RESERVED_FIRST, 6'd1);
        send_command(FUNC_RESERVED_LAST, 6'd2);
    endtask

    // Pushes and pops at both ends, a duplicate push and popping the last element.
    task automatic test_both_ends();
        send_command(FUNC_PUSH_BACK, 6'd5);
        send_command(FUNC_PUSH_FRONT, 6'd63);
        send_command(FUNC_PUSH_BACK, 6'd0);
        send_command(FUNC_PUSH_BACK, 6'd5);
        send_command(FUNC_QUERY, 6'd63);
        send_command(FUNC_POP_FRONT, 6'd0);
        // Pushing the value just popped exercises the membership forwarding.
        send_command(FUNC_PUSH_FRONT, 6'd63);
        send_command(FUNC_POP_BACK, 6'd0);
        send_command(FUNC_POP_FRONT, 6'd0);
        send_command(FUNC_POP_BACK, 6'd0);
    endtask

    // Small domain: the head wraps around, the deque fills and out-of-domain values bounce.
    task automatic test_wrap_and_full();
        write_domain_size(7'd3);
        send_command(FUNC_PUSH_FRONT, 6'd1);
        send_command(FUNC_PUSH_FRONT, 6'd2);
        send_command(FUNC_PUSH_BACK, 6'd0);
        send_command(FUNC_PUSH_BACK, 6'd3);
        send_command(FUNC_QUERY, 6'd3);
        send_command(FUNC_POP_FRONT, 6'd0);
    endtask

    // Domain size zero acts as one; sizes above the maximum saturate.
    task automatic test_domain_limits();
        write_domain_size(7'd0);
        send_command(FUNC_PUSH_BACK, 6'd0);
        send_command(FUNC_PUSH_FRONT, 6'd1);
        write_domain_size(7'd127);
        send_command(FUNC_PUSH_BACK, 6'd63);
        send_command(FUNC_QUERY, 6'd62);
    endtask

    // Random traffic over a range of domain sizes, alternating fill and drain bias.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] sizes[9];
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  value;
        int                push_pct;
        int                pick;
        int                n;
        sizes = '{7'd64, 7'd2, 7'd1, 7'd7, 7'd33, 7'd0, 7'd127, 7'd0, 7'd0};
        sizes[7] = 7'($urandom_range(1, 64));
        sizes[8] = 7'($urandom_range(0, 127));
        foreach (sizes[p]) begin
            write_domain_size(sizes[p]);
            // One phase runs back to back with no idle cycles.
            idling_on = (p != 4);
            n = effective_domain();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == PHASE_ITEMS / 2) wait_for_results();
                push_pct = ((k / 40) % 2 == 0) ? 70 : 35;
                pick     = $urandom_range(0, 99);
                if (pick < 3) begin
                    func = 3'($urandom_range(FUNC_RESERVED_FIRST, FUNC_RESERVED_LAST));
                end else if (pick < 13) begin
                    func = FUNC_QUERY;
                end else if ($urandom_range(0, 99) < push_pct) begin
                    func = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
                end else begin
                    func = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
                end
                // Mostly in-domain values, so pushes get past the range check.
                if ($urandom_range(0, 9) == 0)
                    value = 6'($urandom_range(0, 63));
                else
                    value = 6'($urandom_range(0, n - 1));
                send_command(func, value);
            end
        end
        idling_on = 1'b1;
    endtask

    initial begin
        shadow_domain = 7'd64;
        foreach (shadow_slot[i]) shadow_slot[i] = '0;
        clear_shadow_queue();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_deque_rejects();
        test_both_ends();
        test_wrap_and_full();
        test_domain_limits();
        test_random_traffic();

        wait_for_results();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
